@@ rtl/rprq_pkg.sv @@
// Shared types and constants for the ring priority request queue.
// No dependencies; imported by rprq_cell and ring_priority_request_queue.
package rprq_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned CoordW            = 16;
  localparam int unsigned KeyW              = 16;
  localparam int unsigned TicketW           = 64;
  localparam int unsigned PendingW          = 7;

  typedef enum logic {
    MODE_ENQ  = 1'b0,
    MODE_TAKE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_TAKEN    = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_TAKE = 2'd2
  } state_e;

  // Input transaction
  typedef struct packed {
    mode_e                    mode;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic signed [KeyW-1:0]   prio_key;
  } req_t;

  // Output transaction
  typedef struct packed {
    status_e                  status;
    logic [TicketW-1:0]       ticket;
    logic signed [CoordW-1:0] got_x;
    logic signed [CoordW-1:0] got_y;
    logic signed [CoordW-1:0] got_z;
    logic [PendingW-1:0]      pending;
  } rsp_t;

  // One stored request
  typedef struct packed {
    logic [TicketW-1:0]       ticket;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic signed [KeyW-1:0]   key;
  } entry_t;

  // Running best candidate passed down the chain toward cell 0
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } cand_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic enq_en;
    logic del_en;
  } cell_cmd_t;

endpackage

@@ rtl/rprq_cell.sv @@
// One queue cell: holds one request in age order plus one stage of the
// systolic min-key search. Depends on rprq_pkg.
module rprq_cell import rprq_pkg::*; #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CntW    = 7,
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_cmd_t       cmd_i,
  input  logic [CntW-1:0] count_i,
  input  logic [IdxW-1:0] del_idx_i,
  input  entry_t          new_entry_i,
  input  entry_t          next_entry_i,
  output entry_t          entry_o,
  input  cand_t           cand_i,
  input  logic [IdxW-1:0] cand_idx_i,
  output cand_t           cand_o,
  output logic [IdxW-1:0] cand_idx_o
);

  entry_t          entry_q, entry_d;
  cand_t           cand_q, cand_d;
  logic [IdxW-1:0] cand_idx_q, cand_idx_d;
  logic            live;
  logic            own_wins;

  assign live = CntW'(CellIdx) < count_i;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq_en && (count_i == CntW'(CellIdx))) begin
      entry_d = new_entry_i;
    end else if (cmd_i.del_en && (IdxW'(CellIdx) >= del_idx_i)) begin
      entry_d = next_entry_i;  // close the gap
    end
  end

  // Older (this cell) wins ties
  assign own_wins = live && (!cand_i.valid || (entry_q.key <= cand_i.entry.key));

  always_comb begin
    if (own_wins) begin
      cand_d.valid = 1'b1;
      cand_d.entry = entry_q;
      cand_idx_d   = IdxW'(CellIdx);
    end else begin
      cand_d     = cand_i;
      cand_idx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q    <= entry_d;
    cand_idx_q <= cand_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign entry_o    = entry_q;
  assign cand_o     = cand_q;
  assign cand_idx_o = cand_idx_q;

endmodule

@@ rtl/ring_priority_request_queue.sv @@
// Enqueue and take-on-empty give their result in the cycle after the transaction.
// A take on a non-empty queue gives its result once the min-key search wave has run
// down the cell chain (one cell per cycle) in S_SCAN and S_TAKE has read cell 0.
// One enqueue per cycle while rsp_ready_i keeps up; a take blocks requests until done.
// Reset (async, active low): queue empty, next ticket 1, no result pending;
// stored entries stay undefined and are never read before being written.
module ring_priority_request_queue import rprq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Control state
  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    scan_q, scan_d;
  logic [TicketW-1:0] ticket_q, ticket_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic      req_fire;
  logic      out_free;
  cell_cmd_t cmd;
  entry_t    new_entry;

  // Cell chain wiring; index QueueDepth is the empty end of the chain
  entry_t          entries   [QueueDepth];
  entry_t          next_ent  [QueueDepth];
  cand_t           cands     [QueueDepth+1];
  logic [IdxW-1:0] cand_idxs [QueueDepth+1];

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && out_free;
  assign req_fire    = req_valid_i && req_ready_o;

  assign new_entry.ticket = ticket_q;
  assign new_entry.x      = req_i.coord_x;
  assign new_entry.y      = req_i.coord_y;
  assign new_entry.z      = req_i.coord_z;
  assign new_entry.key    = req_i.prio_key;

  assign cands[QueueDepth]     = '0;
  assign cand_idxs[QueueDepth] = '0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    if (i == QueueDepth - 1) begin : g_last
      assign next_ent[i] = entries[i];  // last cell holds on a delete
    end else begin : g_mid
      assign next_ent[i] = entries[i+1];
    end

    rprq_cell #(
      .IdxW   (IdxW),
      .CntW   (CntW),
      .CellIdx(i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .del_idx_i   (cand_idxs[0]),
      .new_entry_i (new_entry),
      .next_entry_i(next_ent[i]),
      .entry_o     (entries[i]),
      .cand_i      (cands[i+1]),
      .cand_idx_i  (cand_idxs[i+1]),
      .cand_o      (cands[i]),
      .cand_idx_o  (cand_idxs[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire && (req_i.mode == MODE_TAKE) && (count_q != '0)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Entries are frozen; at the end of the scan cell 0 holds the winner
        if (scan_q == CntW'(QueueDepth - 1)) begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    cmd.enq_en  = 1'b0;
    cmd.del_en  = 1'b0;
    count_d     = count_q;
    ticket_d    = ticket_q;
    scan_d      = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          rsp_d       = '0;
          rsp_valid_d = 1'b1;
          if (req_i.mode == MODE_ENQ) begin
            if (count_q == CntW'(QueueDepth)) begin
              rsp_d.status = STAT_FULL;
            end else begin
              cmd.enq_en   = 1'b1;
              count_d      = count_q + 1'b1;
              ticket_d     = ticket_q + 1'b1;  // wraps modulo 2^64
              rsp_d.status = STAT_ENQUEUED;
              rsp_d.ticket = ticket_q;
            end
          end else if (count_q == '0) begin
            rsp_d.status = STAT_EMPTY;
          end else begin
            rsp_valid_d = rsp_valid_q && !rsp_ready_i;
            rsp_d       = rsp_q;
          end
          rsp_d.pending = PendingW'(count_d);
        end
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
      end
      S_TAKE: begin
        if (out_free) begin
          cmd.del_en    = 1'b1;
          count_d       = count_q - 1'b1;
          rsp_valid_d   = 1'b1;
          rsp_d.status  = STAT_TAKEN;
          rsp_d.ticket  = cands[0].entry.ticket;
          rsp_d.got_x   = cands[0].entry.x;
          rsp_d.got_y   = cands[0].entry.y;
          rsp_d.got_z   = cands[0].entry.z;
          rsp_d.pending = PendingW'(count_d);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      ticket_q    <= TicketW'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      ticket_q    <= ticket_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("entry count above depth");

  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAKE) |-> (count_q != '0) && cands[0].valid)
    else $error("take without a winning candidate");

  a_take_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_i.mode == MODE_TAKE) && (count_q != '0) |=> state_q == S_SCAN)
    else $error("non-empty take did not start a scan");

  a_del_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del_en |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not decrement count");

  a_enq_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enq_en |=> ticket_q == $past(ticket_q) + 1'b1)
    else $error("enqueue did not advance ticket");

endmodule
